// ----- rtl/core/mvc_pkg.sv -----
// Package for the mother vertex counter: sizes, microcode word and control store.
`default_nettype none
package mvc_pkg;

  localparam int MaxV    = 64;
  localparam int VIdxW   = $clog2(MaxV);
  localparam int CntW    = $clog2(MaxV + 1);
  localparam int UpcW    = 4;

  // request operations
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // jump conditions
  localparam logic [3:0] C_NEVER      = 4'd0;
  localparam logic [3:0] C_ALWAYS     = 4'd1;
  localparam logic [3:0] C_NOT_FIN    = 4'd2;
  localparam logic [3:0] C_N_ZERO     = 4'd3;
  localparam logic [3:0] C_PEND_EMPTY = 4'd4;
  localparam logic [3:0] C_DIR_REV    = 4'd5;
  localparam logic [3:0] C_SEEN_EQ_N  = 4'd6;
  localparam logic [3:0] C_ROOT_LAST  = 4'd7;
  localparam logic [3:0] C_OUT_BUSY   = 4'd8;

  // program steps
  localparam logic [UpcW-1:0] S_IDLE     = 4'd0;
  localparam logic [UpcW-1:0] S_SETUP    = 4'd1;
  localparam logic [UpcW-1:0] S_WINIT    = 4'd2;
  localparam logic [UpcW-1:0] S_POP      = 4'd3;
  localparam logic [UpcW-1:0] S_EXPAND   = 4'd4;
  localparam logic [UpcW-1:0] S_WDONE    = 4'd5;
  localparam logic [UpcW-1:0] S_CHECK    = 4'd6;
  localparam logic [UpcW-1:0] S_NEXT     = 4'd7;
  localparam logic [UpcW-1:0] S_LOOP     = 4'd8;
  localparam logic [UpcW-1:0] S_REVINIT  = 4'd9;
  localparam logic [UpcW-1:0] S_REVDONE  = 4'd10;
  localparam logic [UpcW-1:0] S_OUTWAIT  = 4'd11;
  localparam logic [UpcW-1:0] S_EMIT     = 4'd12;

  typedef struct packed {
    logic [3:0]      cond;
    logic [UpcW-1:0] target;
    logic            accept;
    logic            setup;
    logic            walk_init;
    logic            pop;
    logic            expand;
    logic            root_inc;
    logic            rev;
    logic            count_load;
    logic            emit;
  } uword_t;

  function automatic uword_t ucode(input logic [UpcW-1:0] a);
    uword_t w;
    w = '0;
    case (a)
      S_IDLE: begin
        w.accept = 1'b1; w.cond = C_NOT_FIN; w.target = S_IDLE;
      end
      S_SETUP: begin
        w.setup = 1'b1; w.cond = C_N_ZERO; w.target = S_OUTWAIT;
      end
      S_WINIT: begin
        w.walk_init = 1'b1;
      end
      S_POP: begin
        w.pop = 1'b1; w.cond = C_PEND_EMPTY; w.target = S_WDONE;
      end
      S_EXPAND: begin
        w.expand = 1'b1; w.cond = C_ALWAYS; w.target = S_POP;
      end
      S_WDONE: begin
        w.cond = C_DIR_REV; w.target = S_REVDONE;
      end
      S_CHECK: begin
        w.cond = C_SEEN_EQ_N; w.target = S_REVINIT;
      end
      S_NEXT: begin
        w.root_inc = 1'b1; w.cond = C_ROOT_LAST; w.target = S_OUTWAIT;
      end
      S_LOOP: begin
        w.cond = C_ALWAYS; w.target = S_WINIT;
      end
      S_REVINIT: begin
        w.rev = 1'b1; w.cond = C_ALWAYS; w.target = S_WINIT;
      end
      S_REVDONE: begin
        w.count_load = 1'b1;
      end
      S_OUTWAIT: begin
        w.cond = C_OUT_BUSY; w.target = S_OUTWAIT;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mvc_ram.sv -----
// Generic single-write, single-read RAM with bit write mask and registered read.
`default_nettype none
module mvc_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [Width-1:0]          wmask,
  input  wire                      re,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < Width; i++) begin
        if (wmask[i]) mem_r[waddr][i] <= wdata[i];
      end
    end
    if (re) rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/mother_vertex_counter.sv -----
// Top level of the mother vertex counter: microcoded sequencer and walk datapath.
`default_nettype none
// An edge request (op 0) sets one bit in the adjacency matrix, which is kept
// twice (by source row and by destination row) so both walks read a whole row
// at a time. A finish request (op 1) runs the walks from a microcode store: each
// walk pops and expands one reached vertex at a time, forward walks go root by
// root until one reaches all vertex_count vertices, and one reverse walk from
// that root gives the count. The worst-case run time is set by the pop/expand
// loop on the matrix read port. The matrix is cleared at once through row valid
// bits, so there is no clearing pass. vertex_count above 64 acts as 64; a count
// of 0, or no vertex reaching all others, gives 0.
module mother_vertex_counter (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire                       in_op,
  input  wire [mvc_pkg::VIdxW-1:0]  in_edge_from,
  input  wire [mvc_pkg::VIdxW-1:0]  in_edge_to,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [mvc_pkg::CntW-1:0]  out_mother_count,
  input  wire                       cfg_we,
  input  wire [mvc_pkg::CntW-1:0]   cfg_data
);
  import mvc_pkg::*;

  uword_t            uw;
  logic [UpcW-1:0]   upc_r, upc_nxt;
  logic              jump;

  logic [CntW-1:0]   vcount_r, vcount_nxt;
  logic [CntW-1:0]   n_sat;
  logic [MaxV-1:0]   mask_n;

  logic [MaxV-1:0]   vis_r, vis_nxt;
  logic [MaxV-1:0]   pend_r, pend_nxt;
  logic [VIdxW-1:0]  root_r, root_nxt;
  logic [CntW-1:0]   seen_r, seen_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              rev_r, rev_nxt;

  logic [MaxV-1:0]   fwd_vld_r, fwd_vld_nxt;
  logic [MaxV-1:0]   trn_vld_r, trn_vld_nxt;
  logic              fwd_vq_r, trn_vq_r;

  logic              out_valid_r, out_valid_nxt;
  logic [CntW-1:0]   out_count_r, out_count_nxt;

  logic              pend_empty;
  logic [MaxV-1:0]   pend_iso;
  logic [VIdxW-1:0]  pop_idx;
  logic              do_pop;
  logic [MaxV-1:0]   fwd_rdata, trn_rdata, row, new_bits;
  logic [MaxV-1:0]   root_hot;

  logic              edge_we;
  logic [MaxV-1:0]   fwd_wdata, fwd_wmask, trn_wdata, trn_wmask;

  assign uw = ucode(upc_r);

  // effective vertex count and the mask of live vertices
  assign n_sat = (vcount_r > CntW'(MaxV)) ? CntW'(MaxV) : vcount_r;
  always_comb begin
    for (int i = 0; i < MaxV; i++) mask_n[i] = (CntW'(i) < n_sat);
  end

  // lowest pending vertex is the next one expanded
  assign pend_empty = (pend_r == '0);
  assign pend_iso   = pend_r & (~pend_r + MaxV'(1));
  always_comb begin
    pop_idx = '0;
    for (int i = 0; i < MaxV; i++) begin
      if (pend_iso[i]) pop_idx = pop_idx | VIdxW'(i);
    end
  end
  assign do_pop = uw.pop && !pend_empty;

  assign row      = rev_r ? (trn_rdata & {MaxV{trn_vq_r}}) : (fwd_rdata & {MaxV{fwd_vq_r}});
  assign new_bits = row & ~vis_r & mask_n;
  assign root_hot = MaxV'(1) << root_r;

  // edge write: an invalid row is written whole so stale data is dropped
  assign edge_we   = uw.accept && in_valid && (in_op == OP_EDGE);
  assign fwd_wdata = MaxV'(1) << in_edge_to;
  assign fwd_wmask = fwd_vld_r[in_edge_from] ? fwd_wdata : '1;
  assign trn_wdata = MaxV'(1) << in_edge_from;
  assign trn_wmask = trn_vld_r[in_edge_to] ? trn_wdata : '1;

  mvc_ram #(.Width(MaxV), .Depth(MaxV)) u_fwd_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (in_edge_from),
    .wdata (fwd_wdata),
    .wmask (fwd_wmask),
    .re    (do_pop),
    .raddr (pop_idx),
    .rdata (fwd_rdata)
  );

  mvc_ram #(.Width(MaxV), .Depth(MaxV)) u_trn_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (in_edge_to),
    .wdata (trn_wdata),
    .wmask (trn_wmask),
    .re    (do_pop),
    .raddr (pop_idx),
    .rdata (trn_rdata)
  );

  // jump condition
  always_comb begin
    case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NOT_FIN:    jump = !(in_valid && (in_op == OP_FINISH));
      C_N_ZERO:     jump = (n_sat == '0);
      C_PEND_EMPTY: jump = pend_empty;
      C_DIR_REV:    jump = rev_r;
      C_SEEN_EQ_N:  jump = (seen_r == n_sat);
      C_ROOT_LAST:  jump = ({1'b0, root_r} + CntW'(1)) == n_sat;
      C_OUT_BUSY:   jump = out_valid_r;
      default:      jump = 1'b1;
    endcase
  end

  always_comb begin
    upc_nxt       = jump ? uw.target : upc_r + UpcW'(1);
    vcount_nxt    = cfg_we ? cfg_data : vcount_r;
    vis_nxt       = vis_r;
    pend_nxt      = pend_r;
    root_nxt      = root_r;
    seen_nxt      = seen_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    fwd_vld_nxt   = fwd_vld_r;
    trn_vld_nxt   = trn_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;

    if (edge_we) begin
      fwd_vld_nxt[in_edge_from] = 1'b1;
      trn_vld_nxt[in_edge_to]   = 1'b1;
    end
    if (uw.setup) begin
      root_nxt  = '0;
      count_nxt = '0;
      rev_nxt   = 1'b0;
    end
    if (uw.walk_init) begin
      vis_nxt  = root_hot;
      pend_nxt = root_hot;
      seen_nxt = '0;
    end
    if (do_pop) begin
      pend_nxt = pend_r & ~pend_iso;
      seen_nxt = seen_r + CntW'(1);
    end
    if (uw.expand) begin
      vis_nxt  = vis_r | new_bits;
      pend_nxt = pend_r | new_bits;
    end
    if (uw.root_inc) root_nxt = root_r + VIdxW'(1);
    if (uw.rev) rev_nxt = 1'b1;
    if (uw.count_load) count_nxt = seen_r;
    if (uw.emit) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = count_r;
      fwd_vld_nxt   = '0;
      trn_vld_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      vcount_r    <= CntW'(MaxV);
      fwd_vld_r   <= '0;
      trn_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      vcount_r    <= vcount_nxt;
      fwd_vld_r   <= fwd_vld_nxt;
      trn_vld_r   <= trn_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vis_r       <= vis_nxt;
    pend_r      <= pend_nxt;
    root_r      <= root_nxt;
    seen_r      <= seen_nxt;
    count_r     <= count_nxt;
    rev_r       <= rev_nxt;
    out_count_r <= out_count_nxt;
    if (do_pop) begin
      fwd_vq_r <= fwd_vld_r[pop_idx];
      trn_vq_r <= trn_vld_r[pop_idx];
    end
  end

  assign in_ready         = uw.accept;
  assign out_valid        = out_valid_r;
  assign out_mother_count = out_count_r;

endmodule
`default_nettype wire
